>>> rtl/core/gld_pkg.sv
// Shared types and constants for the GIF LZW decoder.
// No dependencies; imported by the top level, gld_ctrl and gld_datapath.
`timescale 1ns / 1ps

package gld_pkg;

  localparam int DICT_DEPTH_DEF = 4096;
  localparam logic [3:0] MIN_SIZE_RST = 4'd8;

  localparam logic REQ_FEED  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       need_input;
    logic       end_seen;
    logic       code_error;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_WALK_DT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic restart;   // config write: back to reset values for the new size
    logic feed;      // append data byte to the bit buffer
    logic decode;    // pull one code from the buffer and classify it
    logic walk_rd;   // read dictionary entry of the walk pointer
    logic walk_dt;   // push suffix, follow prefix
    logic finish;    // push root byte, add dictionary entry
    logic pop;       // read top of stack
    logic load;      // load output register
  } cmd_t;

  typedef struct packed {
    logic can_decode;
    logic start_walk;
    logic x_is_string;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/gif_lzw_decoder.sv
// GIF-style variable-width LZW decoder, top level.
// Depends on gld_pkg, gld_ctrl, gld_datapath (which holds the gld_ram instances).
//
// Input channel (in_valid/in_stall/in_data): each transaction is either a feed of one
// compressed byte (req_type 0) or a fetch of one decoded byte (req_type 1).
// Every input transaction produces exactly one output transaction on
// out_valid/out_stall/out_data carrying the decoded byte (if any) and the status flags.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes min_code_size and
// restarts the decoder; it is taken only while no transaction is in flight.
// Steps, accept to result: a feed is taken in S_IDLE and loaded in S_RESULT. A fetch
// passes S_CHECK once per code pulled from the bit buffer, S_WALK and S_WALK_DT per
// dictionary entry walked while a string is unwound onto the stack (one registered
// read of the prefix/suffix RAMs per entry), S_WALK once more to close the string,
// then a pop in S_CHECK and the load in S_RESULT. Fetches served from the stack pop in S_CHECK.
// The output register decouples the sides: a new transaction is accepted while
// a result waits; a stalled receiver holds the next result in its final cycle.
// Reset (rst, synchronous) sets min_code_size to 8 and clears the decoder state;
// no RAM clearing pass is needed.
`timescale 1ns / 1ps

module gif_lzw_decoder #(
  parameter int DICT_DEPTH = gld_pkg::DICT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  gld_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gld_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);

  import gld_pkg::*;

  cmd_t    cmd;
  status_t st;

  gld_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(in_data.req_type),
    .cfg_ready(cfg_ready), .cfg_valid(cfg_valid),
    .st(st), .cmd(cmd)
  );

  gld_datapath #(.DICT_DEPTH(DICT_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_data(cfg_data), .data_byte(in_data.data_byte),
    .out_stall(out_stall), .out_valid(out_valid), .out_data(out_data)
  );

endmodule

>>> rtl/core/gld_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/gld_ctrl.sv
// Sequencer for the LZW decoder: accepts transactions and steps the datapath.
// Depends on gld_pkg.
`timescale 1ns / 1ps

module gld_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             req_type,
  output logic             cfg_ready,
  input  logic             cfg_valid,
  input  gld_pkg::status_t st,
  output gld_pkg::cmd_t    cmd
);

  import gld_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = (state != S_IDLE);
    cfg_ready   = (state == S_IDLE);
    cmd.restart = cfg_valid && cfg_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_FEED) begin
            cmd.feed   = 1'b1;
            state_next = S_RESULT;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (st.can_decode) begin
          cmd.decode = 1'b1;
          state_next = st.start_walk ? S_WALK : S_CHECK;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_WALK: begin
        if (st.x_is_string) begin
          cmd.walk_rd = 1'b1;
          state_next  = S_WALK_DT;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_WALK_DT: begin
        cmd.walk_dt = 1'b1;
        state_next  = S_WALK;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/gld_datapath.sv
// Datapath of the LZW decoder: bit buffer, dictionary, output stack, result register.
// Depends on gld_pkg and gld_ram.
`timescale 1ns / 1ps

module gld_datapath #(
  parameter int DICT_DEPTH = gld_pkg::DICT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  gld_pkg::cmd_t      cmd,
  output gld_pkg::status_t   st,
  input  logic [3:0]         cfg_data,
  input  logic [7:0]         data_byte,
  input  logic               out_stall,
  output logic               out_valid,
  output gld_pkg::out_item_t out_data
);

  import gld_pkg::*;

  localparam int AW = $clog2(DICT_DEPTH);
  localparam logic [AW:0] DEPTH_X = (AW+1)'(DICT_DEPTH);

  logic [3:0]    min_size;
  logic [23:0]   bit_buffer;
  logic [4:0]    bit_count;
  logic [4:0]    code_width;
  logic [AW:0]   next_free;
  logic [AW-1:0] prev_code;
  logic          prev_valid;
  logic [7:0]    first_prev;
  logic [AW:0]   stack_depth;
  logic          table_full;
  logic          ended;
  logic          err;
  logic [AW-1:0] cur_code;
  logic [AW-1:0] walk_x;
  logic          pop_hit;

  function automatic logic [3:0] clamp_size(input logic [3:0] s);
    if (s < 4'd2) return 4'd2;
    if (s > 4'd8) return 4'd8;
    return s;
  endfunction

  logic [3:0]    root, new_root;
  logic [AW-1:0] clear_code, new_clear;
  logic [AW-1:0] mask, code;
  logic [AW:0]   code_x;
  logic          is_clear, is_end, defined, kwk, start_walk;
  logic [AW:0]   nf_inc;
  logic          add_entry;
  logic          push;
  logic [7:0]    push_data;
  logic          pop_en;
  logic [AW-1:0] pfx_rd;
  logic [7:0]    sfx_rd, stk_rd;

  assign root       = clamp_size(min_size);
  assign new_root   = clamp_size(rst ? MIN_SIZE_RST : cfg_data);
  assign clear_code = AW'(1) << root;
  assign new_clear  = AW'(1) << new_root;

  assign mask     = (AW'(1) << code_width) - AW'(1);
  assign code     = bit_buffer[AW-1:0] & mask;
  assign code_x   = {1'b0, code};
  assign is_clear = (code == clear_code);
  assign is_end   = (code == clear_code + AW'(1));
  assign defined  = (code_x < next_free) && (code_x < DEPTH_X);
  // code equal to the next free entry: previous string plus its first byte
  assign kwk        = (code_x == next_free) && prev_valid && !table_full;
  assign start_walk = !is_clear && !is_end && (defined || kwk);

  assign nf_inc    = next_free + (AW+1)'(1);
  assign add_entry = cmd.finish && prev_valid && !table_full && (next_free < DEPTH_X);

  always_comb begin
    push      = 1'b0;
    push_data = first_prev;
    if (cmd.decode && start_walk && kwk) begin
      push      = 1'b1;
      push_data = first_prev;
    end else if (cmd.walk_dt) begin
      push      = 1'b1;
      push_data = sfx_rd;
    end else if (cmd.finish) begin
      push      = 1'b1;
      push_data = walk_x[7:0];
    end
  end

  assign pop_en = cmd.pop && (stack_depth != '0);

  assign st.can_decode  = (stack_depth == '0) && !ended && (bit_count >= code_width);
  assign st.start_walk  = start_walk;
  assign st.x_is_string = (walk_x >= clear_code + AW'(2));
  assign st.out_free    = !out_valid || !out_stall;

  gld_ram #(.WIDTH(AW), .DEPTH(DICT_DEPTH)) u_prefix (
    .clk(clk), .we(add_entry), .waddr(next_free[AW-1:0]), .wdata(prev_code),
    .re(cmd.walk_rd), .raddr(walk_x), .rdata(pfx_rd)
  );

  gld_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_suffix (
    .clk(clk), .we(add_entry), .waddr(next_free[AW-1:0]), .wdata(walk_x[7:0]),
    .re(cmd.walk_rd), .raddr(walk_x), .rdata(sfx_rd)
  );

  gld_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_stack (
    .clk(clk), .we(push && (stack_depth < DEPTH_X)), .waddr(stack_depth[AW-1:0]),
    .wdata(push_data), .re(pop_en), .raddr(AW'(stack_depth - (AW+1)'(1))),
    .rdata(stk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      min_size    <= rst ? MIN_SIZE_RST : cfg_data;
      bit_buffer  <= '0;
      bit_count   <= '0;
      code_width  <= 5'(new_root) + 5'd1;
      next_free   <= {1'b0, new_clear} + (AW+1)'(2);
      prev_code   <= '0;
      prev_valid  <= 1'b0;
      first_prev  <= '0;
      stack_depth <= '0;
      table_full  <= 1'b0;
      ended       <= 1'b0;
      err         <= 1'b0;
      pop_hit     <= 1'b0;
    end else begin
      if (cmd.feed) begin
        pop_hit <= 1'b0;
        if (!ended && bit_count <= 5'd16) begin
          bit_buffer <= bit_buffer | (24'(data_byte) << bit_count);
          bit_count  <= bit_count + 5'd8;
        end
      end
      if (cmd.decode) begin
        bit_buffer <= bit_buffer >> code_width;
        bit_count  <= bit_count - code_width;
        if (is_clear) begin
          code_width <= 5'(root) + 5'd1;
          next_free  <= {1'b0, clear_code} + (AW+1)'(2);
          prev_valid <= 1'b0;
          table_full <= 1'b0;
        end else if (is_end) begin
          ended <= 1'b1;
        end else if (!start_walk) begin
          err <= 1'b1;
        end else begin
          cur_code <= code;
          walk_x   <= kwk ? prev_code : code;
        end
      end
      if (cmd.walk_dt) begin
        walk_x <= pfx_rd;
      end
      if (cmd.finish) begin
        prev_code  <= cur_code;
        first_prev <= walk_x[7:0];
        prev_valid <= 1'b1;
      end
      if (add_entry) begin
        next_free <= nf_inc;
        if (nf_inc >= DEPTH_X) begin
          table_full <= 1'b1;
        end else if (nf_inc == ((AW+1)'(1) << code_width) && code_width < 5'(AW)) begin
          code_width <= code_width + 5'd1;
        end
      end
      if (push && stack_depth < DEPTH_X) begin
        stack_depth <= stack_depth + (AW+1)'(1);
      end else if (pop_en) begin
        stack_depth <= stack_depth - (AW+1)'(1);
      end
      if (cmd.pop) begin
        pop_hit <= pop_en;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.out_byte   <= pop_hit ? stk_rd : 8'd0;
      out_data.out_valid  <= pop_hit;
      out_data.need_input <= (stack_depth == '0) && !ended && (bit_count < code_width);
      out_data.end_seen   <= ended;
      out_data.code_error <= err;
    end
  end

endmodule
